// ===== hdl/dha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dha_pkg;

    localparam int NUM_DESC = 16;
    localparam int IW = $clog2(NUM_DESC);
    localparam int LW = $clog2(NUM_DESC + 1);

    typedef logic [IW-1:0] t_idx;
    typedef logic [LW-1:0] t_link;

    localparam t_link LINK_NULL = t_link'(NUM_DESC);
    localparam logic [32:0] ADDR_TOP = 33'h0_FFFF_FFFC;

    localparam logic [1:0] CFG_HEAP_START = 2'd0;
    localparam logic [1:0] CFG_HEAP_SIZE  = 2'd1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_COLLECT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NO_DESC   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] alloc_size;
        logic [31:0] free_address;
    } t_in_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] block_address;
        logic [8:0]  merges_done;
        logic [8:0]  free_block_count;
    } t_out_rsp;

    typedef struct packed {
        t_idx        raddr;
        logic        base_we;
        t_idx        base_waddr;
        logic [31:0] base_wdata;
        logic        size_we;
        t_idx        size_waddr;
        logic [31:0] size_wdata;
        logic        link_we;
        t_idx        link_waddr;
        t_link       link_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        t_link       link;
    } t_mem_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_A_CHK,
        S_A_W1,
        S_A_W2,
        S_FREE,
        S_F_CHK,
        S_F_W1,
        S_F_W2,
        S_COLL,
        S_C_HD,
        S_C_CHK,
        S_C_M1,
        S_C_M2,
        S_C_RD,
        S_C_END,
        S_DONE
    } t_state;

    function automatic logic is_live(input t_link l);
        return l < t_link'(NUM_DESC);
    endfunction

    function automatic t_idx to_idx(input t_link l);
        return l[IW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dha_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dha_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/dha_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire dha_pkg::t_in_req  i_req,
    input  wire logic [31:0]       i_heap_start,
    input  wire logic [31:0]       i_heap_size,
    output dha_pkg::t_mem_req      o_mem,
    input  wire dha_pkg::t_mem_rsp i_mem,
    output logic                   o_done,
    input  wire logic              i_res_ready,
    output dha_pkg::t_out_rsp      o_res
);
    import dha_pkg::*;

    t_state      r_state, n_state;
    t_link       r_free_head, n_free_head;
    t_link       r_alloc_head, n_alloc_head;
    t_link       r_spare_head, n_spare_head;
    t_link       r_free_cnt, n_free_cnt;

    t_in_req     r_req, n_req;
    t_idx        r_i, n_i;
    t_link       r_h, n_h;
    t_link       r_p, n_p;
    t_link       r_prev, n_prev;
    t_link       r_it, n_it;
    t_link       r_nxt, n_nxt;
    t_link       r_hlink, n_hlink;
    logic [32:0] r_endp, n_endp;
    logic [32:0] r_start, n_start;
    logic [31:0] r_base, n_base;
    logic [31:0] r_hsize, n_hsize;
    logic        r_merged, n_merged;
    t_link       r_merges, n_merges;
    t_status     r_status, n_status;
    logic [31:0] r_addr, n_addr;

    logic [32:0] init_end, init_base, init_rnd;
    logic [32:0] a_end, a_diff, a_start;

    always_comb begin
        init_end = {1'b0, i_heap_start} + {1'b0, i_heap_size};
        if (init_end > ADDR_TOP) begin
            init_end = ADDR_TOP;
        end
        init_rnd  = {1'b0, i_heap_start} + 33'd3;
        init_base = {init_rnd[32:2], 2'b00};
        if (init_base > init_end) begin
            init_base = init_end;
        end
        a_end   = {1'b0, i_mem.base} + {1'b0, i_mem.size};
        a_diff  = a_end - {1'b0, r_req.alloc_size};
        a_start = {a_diff[32:2], 2'b00};
    end

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_alloc_head = r_alloc_head;
        n_spare_head = r_spare_head;
        n_free_cnt   = r_free_cnt;
        n_req        = r_req;
        n_i          = r_i;
        n_h          = r_h;
        n_p          = r_p;
        n_prev       = r_prev;
        n_it         = r_it;
        n_nxt        = r_nxt;
        n_hlink      = r_hlink;
        n_endp       = r_endp;
        n_start      = r_start;
        n_base       = r_base;
        n_hsize      = r_hsize;
        n_merged     = r_merged;
        n_merges     = r_merges;
        n_status     = r_status;
        n_addr       = r_addr;
        o_mem        = '0;
        o_ready      = (r_state == S_IDLE);
        o_done       = 1'b0;
        o_res.status           = r_status;
        o_res.block_address    = r_addr;
        o_res.merges_done      = 9'(r_merges);
        o_res.free_block_count = 9'(r_free_cnt);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_req;
                    n_status = ST_OK;
                    n_addr   = '0;
                    n_merges = '0;
                    n_i      = '0;
                    case (i_req.opcode)
                        OP_INIT:  n_state = S_INIT;
                        OP_ALLOC: n_state = S_ALLOC;
                        OP_FREE:  n_state = S_FREE;
                        default:  n_state = S_COLL;
                    endcase
                end
            end
            S_INIT: begin
                o_mem.link_we    = 1'b1;
                o_mem.link_waddr = r_i;
                o_mem.link_wdata = t_link'(r_i) + t_link'(1);
                if (r_i == '0) begin
                    o_mem.link_wdata = LINK_NULL;
                    o_mem.base_we    = 1'b1;
                    o_mem.base_waddr = r_i;
                    o_mem.base_wdata = init_base[31:0];
                    o_mem.size_we    = 1'b1;
                    o_mem.size_waddr = r_i;
                    o_mem.size_wdata = 32'(init_end - init_base);
                end
                if (r_i == t_idx'(NUM_DESC - 1)) begin
                    n_free_head  = '0;
                    n_spare_head = t_link'(1);
                    n_alloc_head = LINK_NULL;
                    n_free_cnt   = t_link'(1);
                    n_state      = S_DONE;
                end else begin
                    n_i = r_i + t_idx'(1);
                end
            end
            S_ALLOC: begin
                n_h = r_free_head;
                if (!is_live(r_free_head)) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else begin
                    o_mem.raddr = to_idx(r_free_head);
                    n_state     = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (({1'b0, r_req.alloc_size} > a_end) || (a_start < {1'b0, i_mem.base})) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_DONE;
                end else if (!is_live(r_spare_head)) begin
                    n_status = ST_NO_DESC;
                    n_state  = S_DONE;
                end else begin
                    o_mem.raddr = to_idx(r_spare_head);
                    n_start     = a_start;
                    n_endp      = a_end;
                    n_base      = i_mem.base;
                    n_state     = S_A_W1;
                end
            end
            S_A_W1: begin
                o_mem.base_we    = 1'b1;
                o_mem.base_waddr = to_idx(r_spare_head);
                o_mem.base_wdata = r_start[31:0];
                o_mem.size_we    = 1'b1;
                o_mem.size_waddr = to_idx(r_spare_head);
                o_mem.size_wdata = 32'(r_endp - r_start);
                o_mem.link_we    = 1'b1;
                o_mem.link_waddr = to_idx(r_spare_head);
                o_mem.link_wdata = r_alloc_head;
                n_spare_head     = i_mem.link;
                n_alloc_head     = r_spare_head;
                n_addr           = r_start[31:0];
                n_state          = S_A_W2;
            end
            S_A_W2: begin
                o_mem.size_we    = 1'b1;
                o_mem.size_waddr = to_idx(r_h);
                o_mem.size_wdata = 32'(r_start - {1'b0, r_base});
                n_state          = S_DONE;
            end
            S_FREE: begin
                n_p    = r_alloc_head;
                n_prev = LINK_NULL;
                if (!is_live(r_alloc_head)) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    o_mem.raddr = to_idx(r_alloc_head);
                    n_state     = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_mem.base == r_req.free_address) begin
                    n_nxt   = i_mem.link;
                    n_state = S_F_W1;
                end else begin
                    n_prev = r_p;
                    n_p    = i_mem.link;
                    if (is_live(i_mem.link)) begin
                        o_mem.raddr = to_idx(i_mem.link);
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_F_W1: begin
                if (is_live(r_prev)) begin
                    o_mem.link_we    = 1'b1;
                    o_mem.link_waddr = to_idx(r_prev);
                    o_mem.link_wdata = r_nxt;
                end else begin
                    n_alloc_head = r_nxt;
                end
                n_state = S_F_W2;
            end
            S_F_W2: begin
                o_mem.link_we    = 1'b1;
                o_mem.link_waddr = to_idx(r_p);
                o_mem.link_wdata = r_free_head;
                n_free_head      = r_p;
                n_free_cnt       = r_free_cnt + t_link'(1);
                n_state          = S_DONE;
            end
            S_COLL: begin
                n_h = r_free_head;
                if (!is_live(r_free_head)) begin
                    n_state = S_DONE;
                end else begin
                    o_mem.raddr = to_idx(r_free_head);
                    n_state     = S_C_HD;
                end
            end
            S_C_HD: begin
                n_endp      = {1'b0, i_mem.base} + {1'b0, i_mem.size};
                n_hsize     = i_mem.size;
                n_merged    = 1'b0;
                n_it        = r_free_head;
                n_prev      = LINK_NULL;
                o_mem.raddr = to_idx(r_free_head);
                n_state     = S_C_CHK;
            end
            S_C_CHK: begin
                n_nxt = i_mem.link;
                if ((r_it != r_h) && ({1'b0, i_mem.base} == r_endp)) begin
                    n_hsize = r_hsize + i_mem.size;
                    n_state = S_C_M1;
                end else begin
                    if (r_it == r_h) begin
                        n_hlink = i_mem.link;
                    end
                    n_prev = r_it;
                    n_it   = i_mem.link;
                    if (is_live(i_mem.link)) begin
                        o_mem.raddr = to_idx(i_mem.link);
                    end else begin
                        n_state = S_C_END;
                    end
                end
            end
            S_C_M1: begin
                o_mem.size_we    = 1'b1;
                o_mem.size_waddr = to_idx(r_h);
                o_mem.size_wdata = r_hsize;
                if (is_live(r_prev)) begin
                    o_mem.link_we    = 1'b1;
                    o_mem.link_waddr = to_idx(r_prev);
                    o_mem.link_wdata = r_nxt;
                end else begin
                    n_free_head = r_nxt;
                end
                n_state = S_C_M2;
            end
            S_C_M2: begin
                o_mem.size_we    = 1'b1;
                o_mem.size_waddr = to_idx(r_it);
                o_mem.size_wdata = '0;
                o_mem.link_we    = 1'b1;
                o_mem.link_waddr = to_idx(r_it);
                o_mem.link_wdata = r_spare_head;
                n_spare_head     = r_it;
                n_merges         = r_merges + t_link'(1);
                n_free_cnt       = r_free_cnt - t_link'(1);
                n_merged         = 1'b1;
                n_it             = r_nxt;
                if (is_live(r_nxt)) begin
                    n_state = S_C_RD;
                end else begin
                    n_state = S_C_END;
                end
            end
            S_C_RD: begin
                o_mem.raddr = to_idx(r_it);
                n_state     = S_C_CHK;
            end
            S_C_END: begin
                if (r_merged) begin
                    o_mem.raddr = to_idx(r_h);
                    n_state     = S_C_HD;
                end else begin
                    n_h = r_hlink;
                    if (is_live(r_hlink)) begin
                        o_mem.raddr = to_idx(r_hlink);
                        n_state     = S_C_HD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= LINK_NULL;
            r_alloc_head <= LINK_NULL;
            r_spare_head <= LINK_NULL;
            r_free_cnt   <= '0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_alloc_head <= n_alloc_head;
            r_spare_head <= n_spare_head;
            r_free_cnt   <= n_free_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_i      <= n_i;
        r_h      <= n_h;
        r_p      <= n_p;
        r_prev   <= n_prev;
        r_it     <= n_it;
        r_nxt    <= n_nxt;
        r_hlink  <= n_hlink;
        r_endp   <= n_endp;
        r_start  <= n_start;
        r_base   <= n_base;
        r_hsize  <= n_hsize;
        r_merged <= n_merged;
        r_merges <= n_merges;
        r_status <= n_status;
        r_addr   <= n_addr;
    end
endmodule
`default_nettype wire

// ===== hdl/descriptor_heap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------------
// in       | in        | i_in_valid / o_in_ready    | i_in_data (t_in_req)
// out      | out       | o_out_valid / i_out_ready  | o_out_data (t_out_rsp)
// cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one request at a time; descriptors sit in single-port-read memories, one read per cycle
// init: one link write per descriptor; descriptor 0 holds the whole aligned heap
// alloc: carves from the top of the free-list head only; free: walks the allocated list
// collect: per free block, walks the free list and merges any block starting at its end
// reset empties all three lists; out register lets the next request in while a result waits
module descriptor_heap_allocator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dha_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dha_pkg::t_out_rsp      o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import dha_pkg::*;

    logic [31:0] r_heap_start;
    logic [31:0] r_heap_size;
    t_mem_req    mem_req;
    t_mem_rsp    mem_rsp;
    t_out_rsp    res;
    logic        res_done;
    logic        res_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_size  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEAP_START: r_heap_start <= i_cfg_data;
                CFG_HEAP_SIZE:  r_heap_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_req        (i_in_data),
        .i_heap_start (r_heap_start),
        .i_heap_size  (r_heap_size),
        .o_mem        (mem_req),
        .i_mem        (mem_rsp),
        .o_done       (res_done),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    dha_ram #(.W(32), .DEPTH(NUM_DESC)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.base_we),
        .i_waddr (mem_req.base_waddr),
        .i_wdata (mem_req.base_wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rsp.base)
    );

    dha_ram #(.W(32), .DEPTH(NUM_DESC)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.size_we),
        .i_waddr (mem_req.size_waddr),
        .i_wdata (mem_req.size_wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rsp.size)
    );

    dha_ram #(.W(LW), .DEPTH(NUM_DESC)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.link_we),
        .i_waddr (mem_req.link_waddr),
        .i_wdata (mem_req.link_wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rsp.link)
    );

    assign res_ready = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (res_done && res_ready) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_done && res_ready) begin
            o_out_data <= res;
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_descriptor_heap_allocator.sv =====
`timescale 1ns / 1ps
module tb_descriptor_heap_allocator;
    import dha_pkg::*;

    localparam int NDESC = 16;
    localparam int NIL = NDESC;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_req     i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_rsp    o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    descriptor_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // heap model state
    logic [31:0] m_base [NDESC];
    logic [31:0] m_size [NDESC];
    int          m_link [NDESC];
    int          m_free_head, m_alloc_head, m_spare_head;
    logic [31:0] m_heap_start, m_heap_size;

    t_in_req  pending_reqs[$];
    t_out_rsp expected_rsps[$];
    int       errors;
    bit       quiet_mode;
    bit       long_hold;
    int       in_gap, out_gap, hold_cnt;
    int       issued_cnt;
    logic [31:0] live_addrs[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int free_count();
        int n;
        int p;
        n = 0;
        p = m_free_head;
        while (p < NDESC && n < NDESC) begin
            n++;
            p = m_link[p];
        end
        return n;
    endfunction

    function automatic t_out_rsp heap_predict(t_in_req r);
        t_out_rsp o;
        logic [33:0] hend, hbase, aend, astart;
        int h, d, prev, p, it, nxt, guard, merges;
        bit found, merged;
        o = '0;
        o.status = ST_OK;
        merges = 0;
        case (r.opcode)
            OP_INIT: begin
                hend = {2'b0, m_heap_start} + {2'b0, m_heap_size};
                hbase = ({2'b0, m_heap_start} + 34'd3) & ~34'd3;
                if (hend > 34'h0_FFFF_FFFC) hend = 34'h0_FFFF_FFFC;
                if (hbase > hend) hbase = hend;
                for (int i = 0; i < NDESC; i++) m_link[i] = i + 1;
                m_base[0] = hbase[31:0];
                m_size[0] = 32'(hend - hbase);
                m_link[0] = NIL;
                m_free_head = 0;
                m_spare_head = 1;
                m_alloc_head = NIL;
            end
            OP_ALLOC: begin
                h = m_free_head;
                if (h >= NDESC) begin
                    o.status = ST_NO_SPACE;
                end else begin
                    aend = {2'b0, m_base[h]} + {2'b0, m_size[h]};
                    if ({2'b0, r.alloc_size} > aend) begin
                        o.status = ST_NO_SPACE;
                    end else begin
                        astart = (aend - {2'b0, r.alloc_size}) & ~34'd3;
                        if (astart < {2'b0, m_base[h]}) begin
                            o.status = ST_NO_SPACE;
                        end else if (m_spare_head >= NDESC) begin
                            o.status = ST_NO_DESC;
                        end else begin
                            d = m_spare_head;
                            m_spare_head = m_link[d];
                            m_base[d] = astart[31:0];
                            m_size[d] = 32'(aend - astart);
                            m_size[h] = 32'(astart - {2'b0, m_base[h]});
                            m_link[d] = m_alloc_head;
                            m_alloc_head = d;
                            o.block_address = astart[31:0];
                        end
                    end
                end
            end
            OP_FREE: begin
                prev = NIL;
                p = m_alloc_head;
                guard = 0;
                found = 0;
                while (p < NDESC && guard < NDESC && !found) begin
                    if (m_base[p] == r.free_address) begin
                        if (prev < NDESC) m_link[prev] = m_link[p];
                        else m_alloc_head = m_link[p];
                        m_link[p] = m_free_head;
                        m_free_head = p;
                        found = 1;
                    end else begin
                        prev = p;
                        p = m_link[p];
                        guard++;
                    end
                end
                if (!found) o.status = ST_NOT_FOUND;
            end
            default: begin
                h = m_free_head;
                while (h < NDESC) begin
                    merged = 0;
                    aend = {2'b0, m_base[h]} + {2'b0, m_size[h]};
                    prev = NIL;
                    it = m_free_head;
                    while (it < NDESC) begin
                        nxt = m_link[it];
                        if (it != h && {2'b0, m_base[it]} == aend) begin
                            m_size[h] = m_size[h] + m_size[it];
                            if (prev < NDESC) m_link[prev] = nxt;
                            else m_free_head = nxt;
                            m_size[it] = '0;
                            m_link[it] = m_spare_head;
                            m_spare_head = it;
                            merges++;
                            merged = 1;
                        end else begin
                            prev = it;
                        end
                        it = nxt;
                    end
                    if (!merged) h = m_link[h];
                end
                o.merges_done = 9'(merges);
            end
        endcase
        o.free_block_count = 9'(free_count());
        return o;
    endfunction

    function automatic t_in_req make_req(t_op op, logic [31:0] sz, logic [31:0] fa);
        t_in_req r;
        r.opcode = op;
        r.alloc_size = sz;
        r.free_address = fa;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_in_data <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                issued_cnt <= issued_cnt + 1;
                if (!quiet_mode && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 5);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap <= 0;
            hold_cnt <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $realtime, o_out_data);
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_out_data.status !== exp_rsp.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 exp_rsp.status, o_out_data.status);
                        errors++;
                    end
                    if (o_out_data.block_address !== exp_rsp.block_address) begin
                        $display("%0t: block_address expected %h actual %h", $realtime,
                                 exp_rsp.block_address, o_out_data.block_address);
                        errors++;
                    end
                    if (o_out_data.merges_done !== exp_rsp.merges_done) begin
                        $display("%0t: merges_done expected %0d actual %0d", $realtime,
                                 exp_rsp.merges_done, o_out_data.merges_done);
                        errors++;
                    end
                    if (o_out_data.free_block_count !== exp_rsp.free_block_count) begin
                        $display("%0t: free_block_count expected %0d actual %0d", $realtime,
                                 exp_rsp.free_block_count, o_out_data.free_block_count);
                        errors++;
                    end
                end
            end
            if (long_hold) begin
                hold_cnt <= hold_cnt + 1;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                out_gap <= $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // push a request and its expected response
    task automatic queue_req(t_in_req r);
        t_out_rsp e;
        e = heap_predict(r);
        pending_reqs.push_back(r);
        expected_rsps.push_back(e);
        if (r.opcode == OP_INIT) live_addrs.delete();
        if (r.opcode == OP_ALLOC && e.status == ST_OK) live_addrs.push_back(e.block_address);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_START) m_heap_start = val;
        else m_heap_size = val;
    endtask

    task automatic random_req(logic [31:0] heap_len);
        int k;
        logic [31:0] a;
        k = $urandom_range(0, 99);
        if (k < 45) begin
            if ($urandom_range(0, 9) == 0)
                queue_req(make_req(OP_ALLOC, $urandom(), $urandom()));
            else
                queue_req(make_req(OP_ALLOC, $urandom_range(0, heap_len / 6 + 8), $urandom()));
        end else if (k < 80) begin
            if (live_addrs.size() > 0 && $urandom_range(0, 5) != 0) begin
                k = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[k];
                live_addrs.delete(k);
                queue_req(make_req(OP_FREE, $urandom(), a));
            end else begin
                queue_req(make_req(OP_FREE, $urandom(), $urandom()));
            end
        end else if (k < 97) begin
            queue_req(make_req(OP_COLLECT, $urandom(), $urandom()));
        end else begin
            queue_req(make_req(OP_INIT, $urandom(), $urandom()));
        end
    endtask

    initial begin
        logic [31:0] starts [6];
        logic [31:0] sizes [6];
        errors = 0;
        quiet_mode = 0;
        long_hold = 0;
        issued_cnt = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_HEAP_START;
        i_cfg_data = '0;
        for (int i = 0; i < NDESC; i++) begin
            m_base[i] = '0; m_size[i] = '0; m_link[i] = 0;
        end
        m_free_head = NIL; m_alloc_head = NIL; m_spare_head = NIL;
        m_heap_start = '0; m_heap_size = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // use before init
        queue_req(make_req(OP_ALLOC, 32'd4, 32'd0));
        queue_req(make_req(OP_FREE, 32'd0, 32'd0));
        queue_req(make_req(OP_COLLECT, 32'd0, 32'd0));
        drain();

        cfg_write(CFG_HEAP_START, 32'h0000_1001);
        cfg_write(CFG_HEAP_SIZE, 32'd400);
        queue_req(make_req(OP_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_req(make_req(OP_ALLOC, 32'd0, 32'd0));
        queue_req(make_req(OP_ALLOC, 32'd13, 32'd0));
        queue_req(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0));
        queue_req(make_req(OP_ALLOC, 32'd500, 32'd0));
        for (int i = 0; i < 15; i++) queue_req(make_req(OP_ALLOC, 32'd8, 32'd0));
        queue_req(make_req(OP_FREE, 32'd0, 32'h1234_5678));
        while (live_addrs.size() > 0)
            queue_req(make_req(OP_FREE, 32'd0, live_addrs.pop_back()));
        queue_req(make_req(OP_COLLECT, 32'd0, 32'd0));
        drain();

        // region beyond address space, start past end
        cfg_write(CFG_HEAP_START, 32'hFFFF_FFFF);
        cfg_write(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
        queue_req(make_req(OP_INIT, 32'd0, 32'd0));
        queue_req(make_req(OP_ALLOC, 32'd0, 32'd0));
        drain();

        starts = '{32'h0, 32'hFFFF_FF00, 32'h0000_0002, 32'h8000_0003, 32'h0, 32'h4000_0000};
        sizes  = '{32'h0, 32'h0000_0200, 32'd1024, 32'd96, 32'hFFFF_FFFF, 32'd4096};
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_HEAP_START, starts[ph]);
            cfg_write(CFG_HEAP_SIZE, sizes[ph]);
            queue_req(make_req(OP_INIT, $urandom(), $urandom()));
            if (ph == 2) begin
                // fill the pipeline while the receiver holds off
                for (int i = 0; i < 20; i++) random_req(sizes[ph]);
                long_hold = 1;
                while (hold_cnt < 300) @(posedge i_clk);
                long_hold = 0;
            end
            if (ph == 5) quiet_mode = 1;
            for (int i = 0; i < 110; i++) random_req(sizes[ph] > 32'h10000 ? 32'h10000 : sizes[ph]);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
